>>> rtl/assert_macros.svh
// Assertion macros used by the flow rate threshold detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with asynchronous active-low reset disable.
`define FRTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check of the cycle that follows a trigger.
`define FRTD_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/frtd_pkg.sv
// Shared types and constants of the flow rate threshold detector.
`timescale 1ns / 1ps
package frtd_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] GOOD_TAG        = 16'hdead;
  localparam logic [31:0] THRESHOLD_RESET = 32'd5000;
  localparam logic [31:0] COUNT_MAX       = 32'hffff_ffff;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_THRESHOLD = '0;

  typedef enum logic [0:0] {
    OP_PACKET = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_FLOW    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_BAD_TAG = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] src_ipv4;
    logic [31:0] dst_ipv4;
    logic [63:0] src6_high;
    logic [63:0] src6_low;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_key_t;

  typedef struct packed {
    logic              en;
    logic              key_en;
    logic [ADDR_W-1:0] addr;
    flow_key_t         key;
    logic [31:0]       count;
  } tbl_wr_t;

endpackage

>>> rtl/frtd_table.sv
// Flow table storage: key memory and count memory, registered read.
`timescale 1ns / 1ps
module frtd_table (
  input  logic                        clk_i,
  input  logic [frtd_pkg::ADDR_W-1:0] rd_addr_i,
  input  frtd_pkg::tbl_wr_t           wr_i,
  output frtd_pkg::flow_key_t         rd_key_o,
  output logic [31:0]                 rd_count_o
);
  import frtd_pkg::*;

  flow_key_t   key_mem [TABLE_DEPTH];
  logic [31:0] cnt_mem [TABLE_DEPTH];

  // Keys are written only when a flow claims an entry.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.key_en) begin
      key_mem[wr_i.addr] <= wr_i.key;
    end
    rd_key_o <= key_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      cnt_mem[wr_i.addr] <= wr_i.count;
    end
    rd_count_o <= cnt_mem[rd_addr_i];
  end

endmodule

>>> rtl/flow_rate_threshold_detector.sv
// Top level of the flow rate threshold detector.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o op, record tag, flow key fields
// output    out        out_valid_o/ out_stall_i kind, flow src/proto/sport/count, last
// config    in         APB write/read          count_threshold at byte address 0
//
// A packet is accepted, then the valid entries are read in order, each one compared
// once its read data is in the read register, until a hit or the end of the prefix.
// A window tick is accepted, then each valid entry is read (S_TSCAN) and checked
// (S_TCHK), and then the done result is sent (S_TDONE); a stalled result
// transfer holds the scan until the output register is free.
// Reset empties the table at once through the fill count; no clearing pass.
// A finished result waits in the output register while the next item is taken.
//
module flow_rate_threshold_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [15:0]                  record_tag_i,
  input  logic [31:0]                  src_ipv4_i,
  input  logic [31:0]                  dst_ipv4_i,
  input  logic [63:0]                  src_ipv6_high_i,
  input  logic [63:0]                  src_ipv6_low_i,
  input  logic [7:0]                   proto_i,
  input  logic [15:0]                  sport_i,
  input  logic [15:0]                  dport_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [31:0]                  flow_src_ip_o,
  output logic [7:0]                   flow_proto_o,
  output logic [15:0]                  flow_sport_o,
  output logic [31:0]                  flow_count_o,
  output logic                         last_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frtd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import frtd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_BAD    = 3'd2;
  localparam logic [2:0] S_TSCAN  = 3'd3;
  localparam logic [2:0] S_TCHK   = 3'd4;
  localparam logic [2:0] S_TDONE  = 3'd5;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_DEPTH);

  logic [2:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;     // valid entries form the prefix [0, fill)
  logic [FILL_W-1:0] idx_q, idx_d;       // next entry to read
  logic              pend_q, pend_d;     // read data for cmp_q is in the read register
  logic [ADDR_W-1:0] cmp_q, cmp_d;
  logic [31:0]       thr_q;
  flow_key_t         item_key_q;

  logic              out_valid_q;
  logic              out_load;
  logic [1:0]        out_kind_d,  out_kind_q;
  logic [31:0]       out_ip_d,    out_ip_q;
  logic [7:0]        out_proto_d, out_proto_q;
  logic [15:0]       out_sport_d, out_sport_q;
  logic [31:0]       out_cnt_d,   out_cnt_q;
  logic              out_last_d,  out_last_q;
  logic              out_free;

  logic              in_xfer;
  logic              cfg_wr;
  tbl_wr_t           tbl_wr;
  flow_key_t         rd_key;
  logic [31:0]       rd_count;
  logic              key_hit;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[PADDR_W-1:2] == REG_THRESHOLD);
  assign prdata = (paddr[PADDR_W-1:2] == REG_THRESHOLD) ? thr_q : '0;

  // ---------------------------------------------------------------- handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign flow_src_ip_o = out_ip_q;
  assign flow_proto_o  = out_proto_q;
  assign flow_sport_o  = out_sport_q;
  assign flow_count_o  = out_cnt_q;
  assign last_o        = out_last_q;

  // ---------------------------------------------------------------- table
  frtd_table u_table (
    .clk_i      (clk_i),
    .rd_addr_i  (idx_q[ADDR_W-1:0]),
    .wr_i       (tbl_wr),
    .rd_key_o   (rd_key),
    .rd_count_o (rd_count)
  );

  assign key_hit = (rd_key == item_key_q);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    cmp_d       = cmp_q;
    out_load    = 1'b0;
    out_kind_d  = KIND_FLOW;
    out_ip_d    = '0;
    out_proto_d = '0;
    out_sport_d = '0;
    out_cnt_d   = '0;
    out_last_d  = 1'b0;
    tbl_wr        = '0;
    tbl_wr.key    = item_key_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_d = '0;
          if (op_i == OP_TICK) begin
            state_d = S_TSCAN;
          end else if (record_tag_i != GOOD_TAG) begin
            state_d = S_BAD;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // Read one entry per cycle and compare the one read the cycle before.
        if (pend_q && key_hit) begin
          tbl_wr.en    = 1'b1;
          tbl_wr.addr  = cmp_q;
          tbl_wr.count = (rd_count == COUNT_MAX) ? rd_count : rd_count + 32'd1;
          state_d      = S_IDLE;
        end else if (idx_q != fill_q) begin
          pend_d = 1'b1;
          cmp_d  = idx_q[ADDR_W-1:0];
          idx_d  = idx_q + FILL_W'(1);
        end else begin
          // No match in the valid prefix: claim the next entry if there is one.
          if (fill_q != FILL_FULL) begin
            tbl_wr.en     = 1'b1;
            tbl_wr.key_en = 1'b1;
            tbl_wr.addr   = fill_q[ADDR_W-1:0];
            tbl_wr.count  = '0;
            fill_d        = fill_q + FILL_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_BAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_BAD_TAG;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_TSCAN: begin
        state_d = (idx_q == fill_q) ? S_TDONE : S_TCHK;
      end
      S_TCHK: begin
        // Read address still points at idx_q, so the data holds while stalled.
        if (rd_count > thr_q) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_kind_d  = KIND_FLOW;
            out_ip_d    = rd_key.src_ipv4;
            out_proto_d = rd_key.proto;
            out_sport_d = rd_key.sport;
            out_cnt_d   = rd_count;
            idx_d       = idx_q + FILL_W'(1);
            state_d     = S_TSCAN;
          end
        end else begin
          idx_d   = idx_q + FILL_W'(1);
          state_d = S_TSCAN;
        end
      end
      S_TDONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_DONE;
          out_last_d = 1'b1;
          fill_d     = '0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      cmp_q       <= '0;
      thr_q       <= THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      cmp_q   <= cmp_d;
      if (cfg_wr) begin
        thr_q <= pwdata;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the item key on transfer, results on load.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_key_q <= '{src_ipv4:  src_ipv4_i,
                      dst_ipv4:  dst_ipv4_i,
                      src6_high: src_ipv6_high_i,
                      src6_low:  src_ipv6_low_i,
                      proto:     proto_i,
                      sport:     sport_i,
                      dport:     dport_i};
    end
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_ip_q    <= out_ip_d;
      out_proto_q <= out_proto_d;
      out_sport_q <= out_sport_d;
      out_cnt_q   <= out_cnt_d;
      out_last_q  <= out_last_d;
    end
  end

  // ---------------------------------------------------------------- checks
  `FRTD_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FILL_FULL, "fill beyond table depth")
  `FRTD_ASSERT(a_load_free, clk_i, rst_ni, !(out_load && !out_free), "stalled result overwritten")
  `FRTD_ASSERT(a_pend_in_prefix, clk_i, rst_ni, !pend_q || ({1'b0, cmp_q} < fill_q),
               "compare past fill")
  `FRTD_ASSERT_NEXT(a_done_clears, clk_i, rst_ni, (state_q == S_TDONE) && out_free,
                    fill_q == '0, "table not cleared after window end")

endmodule
